// ----- sv/spim_pkg.sv -----
`timescale 1ns / 1ps

package spim_pkg;

    localparam int unsigned MAX_BITS        = 32;
    localparam int unsigned MIN_HALF_PERIOD = 1;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned SIZE_W   = 6;
    localparam int unsigned TICK_W   = 16;
    localparam int unsigned CSD_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CSD  = 2'd2;

    localparam logic [1:0]        MODE_RESET = 2'd0;
    localparam logic [TICK_W-1:0] HALF_RESET = 16'd20;
    localparam logic [CSD_W-1:0]  CSD_RESET  = 8'd1;

    localparam logic [SIZE_W-1:0] SIZE_8  = 6'd8;
    localparam logic [SIZE_W-1:0] SIZE_16 = 6'd16;
    localparam logic [SIZE_W-1:0] SIZE_32 = 6'd32;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LEAD   = 3'd1,
        PH_HALF_A = 3'd2,
        PH_HALF_B = 3'd3,
        PH_TRAIL  = 3'd4
    } phase_t;

    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] tx_data;
        logic [SIZE_W-1:0] size_bits;
        logic              miso;
    } item_t;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic              sck;
        logic              mosi;
        logic              cs_n;
        logic              busy_res;
        logic              done_res;
        logic [DATA_W-1:0] rx_data;
        logic              bad_size;
    } result_t;

endpackage

// ----- sv/spim_if.sv -----
`timescale 1ns / 1ps

interface spim_req_if;
    import spim_pkg::*;
    logic              valid;
    logic              ready;
    logic              op;
    logic [DATA_W-1:0] tx_data;
    logic [SIZE_W-1:0] size_bits;
    logic              miso;

    modport source (output valid, op, tx_data, size_bits, miso, input ready);
    modport sink   (input valid, op, tx_data, size_bits, miso, output ready);
endinterface

interface spim_rsp_if;
    import spim_pkg::*;
    logic              valid;
    logic              ready;
    logic              sck;
    logic              mosi;
    logic              cs_n;
    logic              busy_res;
    logic              done_res;
    logic [DATA_W-1:0] rx_data;
    logic              bad_size;

    modport source (output valid, sck, mosi, cs_n, busy_res, done_res, rx_data, bad_size,
                    input ready);
    modport sink   (input valid, sck, mosi, cs_n, busy_res, done_res, rx_data, bad_size,
                    output ready);
endinterface

interface spim_cfg_if;
    import spim_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/spim_seq.sv -----
`timescale 1ns / 1ps

module spim_seq
    import spim_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_wr_t cfg_wr,
    output result_t result
);

    logic [1:0]        mode_reg,  mode_next;
    logic [TICK_W-1:0] half_reg,  half_next;
    logic [CSD_W-1:0]  csd_reg,   csd_next;
    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] tick_reg,  tick_next;
    logic [SIZE_W-1:0] bitc_reg,  bitc_next;
    logic [DATA_W-1:0] send_reg,  send_next;
    logic [DATA_W-1:0] recv_reg,  recv_next;
    logic [SIZE_W-1:0] size_reg,  size_next;
    logic              sck_reg,   sck_next;
    logic              mosi_reg,  mosi_next;
    logic              csn_reg,   csn_next;
    logic              done_next;
    logic              bad_next;
    logic [DATA_W-1:0] word_next;

    always_comb
    begin
        logic              cpol;
        logic              cpha;
        logic [TICK_W-1:0] eff_half;
        logic [TICK_W-1:0] tick_inc;
        logic [TICK_W-1:0] csd_ext;
        logic              size_ok;
        logic              do_begin;
        logic              do_finish;
        logic [4:0]        bit_sel;

        cpol      = mode_reg[1];
        cpha      = mode_reg[0];
        eff_half  = (half_reg < TICK_W'(MIN_HALF_PERIOD)) ? TICK_W'(MIN_HALF_PERIOD) : half_reg;
        tick_inc  = tick_reg + 16'd1;
        csd_ext   = {8'd0, csd_reg};
        size_ok   = (item.size_bits == SIZE_8 || item.size_bits == SIZE_16 ||
                     item.size_bits == SIZE_32) && (item.size_bits <= SIZE_W'(MAX_BITS));
        do_begin  = 1'b0;
        do_finish = 1'b0;
        bit_sel   = '0;

        mode_next  = mode_reg;
        half_next  = half_reg;
        csd_next   = csd_reg;
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bitc_next  = bitc_reg;
        send_next  = send_reg;
        recv_next  = recv_reg;
        size_next  = size_reg;
        sck_next   = sck_reg;
        mosi_next  = mosi_reg;
        csn_next   = csn_reg;
        done_next  = 1'b0;
        bad_next   = 1'b0;
        word_next  = '0;

        if (step)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (item.op)
                    begin
                        if (!size_ok)
                        begin
                            done_next = 1'b1;
                            bad_next  = 1'b1;
                        end
                        else
                        begin
                            size_next = item.size_bits;
                            send_next = (item.size_bits >= SIZE_W'(DATA_W)) ? item.tx_data
                                      : item.tx_data & ~({DATA_W{1'b1}} << item.size_bits);
                            recv_next = '0;
                            bitc_next = '0;
                            csn_next  = 1'b0;
                            if (csd_reg == '0)
                            begin
                                do_begin = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_LEAD;
                                tick_next  = '0;
                            end
                        end
                    end
                end
                PH_LEAD:
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= csd_ext)
                    begin
                        do_begin = 1'b1;
                    end
                end
                PH_HALF_A:
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= eff_half)
                    begin
                        tick_next  = '0;
                        recv_next  = {recv_reg[DATA_W-2:0], item.miso};
                        sck_next   = cpha ? cpol : ~cpol;
                        phase_next = PH_HALF_B;
                    end
                end
                PH_HALF_B:
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= eff_half)
                    begin
                        tick_next = '0;
                        if (!cpha)
                        begin
                            sck_next = cpol;
                        end
                        bitc_next = bitc_reg + 6'd1;
                        if (bitc_next >= size_reg)
                        begin
                            if (csd_reg == '0)
                            begin
                                do_finish = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_TRAIL;
                            end
                        end
                        else
                        begin
                            do_begin = 1'b1;
                        end
                    end
                end
                PH_TRAIL:
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= csd_ext)
                    begin
                        do_finish = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                end
            endcase

            if (do_begin)
            begin
                bit_sel    = 5'(size_next - 6'd1);
                mosi_next  = send_next[bit_sel];
                send_next  = send_next << 1;
                if (cpha)
                begin
                    sck_next = ~cpol;
                end
                phase_next = PH_HALF_A;
                tick_next  = '0;
            end

            if (do_finish)
            begin
                csn_next   = 1'b1;
                done_next  = 1'b1;
                word_next  = recv_next;
                phase_next = PH_IDLE;
                tick_next  = '0;
            end
        end

        if (cfg_wr.valid)
        begin
            case (cfg_wr.index)
                REG_MODE:
                begin
                    mode_next = cfg_wr.data[1:0];
                    if (phase_reg == PH_IDLE)
                    begin
                        sck_next = cfg_wr.data[1];
                    end
                end
                REG_HALF: half_next = cfg_wr.data;
                REG_CSD:  csd_next  = cfg_wr.data[CSD_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        result.sck      = sck_next;
        result.mosi     = mosi_next;
        result.cs_n     = csn_next;
        result.busy_res = (phase_next != PH_IDLE);
        result.done_res = done_next;
        result.rx_data  = word_next;
        result.bad_size = bad_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RESET;
            half_reg  <= HALF_RESET;
            csd_reg   <= CSD_RESET;
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bitc_reg  <= '0;
            send_reg  <= '0;
            recv_reg  <= '0;
            size_reg  <= '0;
            sck_reg   <= MODE_RESET[1];
            mosi_reg  <= 1'b0;
            csn_reg   <= 1'b1;
        end
        else
        begin
            mode_reg  <= mode_next;
            half_reg  <= half_next;
            csd_reg   <= csd_next;
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bitc_reg  <= bitc_next;
            send_reg  <= send_next;
            recv_reg  <= recv_next;
            size_reg  <= size_next;
            sck_reg   <= sck_next;
            mosi_reg  <= mosi_next;
            csn_reg   <= csn_next;
        end
    end

    a_idle_cs_high: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> csn_reg)
        else $error("chip select low while idle");

    a_bit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HALF_A || phase_reg == PH_HALF_B) |-> (bitc_reg < size_reg))
        else $error("bit count past transfer size");

    a_cs_rise_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(csn_reg) |-> $past(step))
        else $error("chip select rose without a request");

endmodule

// ----- sv/spi_master_mode0_3.sv -----
`timescale 1ns / 1ps

// SPI master sequencer; each request on req is one tick of the bit clock.
// A request with op set while idle starts a transfer of 8, 16 or 32 bits;
// any other size returns done_res with bad_size and zero rx_data at once.
// Each request yields exactly one response on rsp carrying the pin levels
// (sck, mosi, cs_n) after that tick, busy_res, done_res and rx_data.
// cfg writes spi_mode (index 0), half_period (index 1) and cs_delay
// (index 2); cfg is always ready and should be written only while idle.
// Response: registered; the response for a request is valid the cycle after acceptance.
// Throughput: one request per cycle unless rsp stalls; the next-state logic
// is a single pass from the state registers to the response register.
// Stall: req.ready stays high while the response register is empty or is
// being taken; with rsp.ready low and a response held, req.ready drops.
// Reset: idle, cs_n high, sck at polarity 0, mosi low, registers at
// spi_mode 0, half_period 20, cs_delay 1; no response pending.
module spi_master_mode0_3
    import spim_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    spim_req_if.sink   req,
    spim_rsp_if.source rsp,
    spim_cfg_if.sink   cfg
);

    logic    step;
    item_t   item;
    cfg_wr_t cfg_wr;
    result_t result;
    result_t rsp_reg;
    logic    rsp_valid_reg;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign step      = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign item.op        = req.op;
    assign item.tx_data   = req.tx_data;
    assign item.size_bits = req.size_bits;
    assign item.miso      = req.miso;

    assign cfg_wr.valid = cfg.valid;
    assign cfg_wr.index = cfg.index;
    assign cfg_wr.data  = cfg.data;

    spim_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .cfg_wr (cfg_wr),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.sck      = rsp_reg.sck;
    assign rsp.mosi     = rsp_reg.mosi;
    assign rsp.cs_n     = rsp_reg.cs_n;
    assign rsp.busy_res = rsp_reg.busy_res;
    assign rsp.done_res = rsp_reg.done_res;
    assign rsp.rx_data  = rsp_reg.rx_data;
    assign rsp.bad_size = rsp_reg.bad_size;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |-> !step)
        else $error("response overwritten while stalled");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.done_res) |-> !rsp_reg.busy_res)
        else $error("done shown while busy");

    a_bad_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.bad_size) |-> (rsp_reg.done_res && rsp_reg.rx_data == '0))
        else $error("bad size without done or with data");

endmodule
